// ===== rtl/grot_pkg.sv =====
// grot_pkg: shared constants, types and binary32 helpers for the givens rotation core
// used by grot_fmul, grot_fadd and givens_rotation_fp32_core; no dependencies

package grot_pkg;

  localparam int unsigned FpW = 32;
  localparam int unsigned ExpW = 8;
  localparam int unsigned ManW = 23;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [FpW-1:0] OneBits = 32'h3F80_0000;
  localparam logic [FpW-1:0] CanonNan = 32'h7FC0_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COSINE = 1'b0,
    REG_SINE   = 1'b1
  } cfg_reg_e;

  // unpacked class of one binary32 operand
  typedef struct packed {
    logic       sign;
    logic       is_zero;
    logic       is_inf;
    logic       is_nan;
    logic [9:0] exp;   // unbiased + bias, subnormals use exponent 1
    logic [23:0] sig;  // with hidden bit
  } fp_unp_t;

  function automatic fp_unp_t fp_unpack(input logic [FpW-1:0] a);
    fp_unp_t u;
    u.sign    = a[31];
    u.is_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    u.is_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    u.is_zero = (a[30:0] == '0);
    u.exp     = (a[30:23] == '0) ? 10'd1 : {2'b00, a[30:23]};
    u.sig     = {(a[30:23] != '0), a[22:0]};
    return u;
  endfunction

  // leading zero count of a 48-bit word
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // round a normalized value: sig[47] is the leading one, exp is its biased exponent
  // (may be <= 0 for subnormal results)
  function automatic logic [FpW-1:0] fp_round(input logic sign, input logic signed [11:0] exp,
                                              input logic [47:0] sig, input logic sticky_in);
    logic [FpW-1:0] r;
    logic [47:0]    s;
    logic           st;
    logic [11:0]    sh;
    logic signed [11:0] e;
    logic [24:0]    m;
    logic           g;
    logic           rs;
    logic           inc;
    s  = sig;
    st = sticky_in;
    e  = exp;
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh > 12'd48) begin
        st = st | (s != '0);
        s = '0;
      end else begin
        for (int k = 0; k < 48; k++) begin
          if (k < int'(sh)) st = st | s[k];
        end
        s = s >> sh;
      end
      e = 12'sd0;
    end
    m   = {1'b0, s[47:24]};
    g   = s[23];
    rs  = st | (s[22:0] != '0);
    inc = g & (rs | m[0]);
    m   = m + 25'(inc);
    if (e == 12'sd0) begin
      // subnormal: hidden bit set after rounding means it became normal
      r = {sign, 7'd0, m[23], m[22:0]};
    end else if (m[24]) begin
      e = e + 12'sd1;
      r = (e >= 12'sd255) ? {sign, 8'hFF, 23'd0} : {sign, e[7:0], m[23:1]};
    end else begin
      r = (e >= 12'sd255) ? {sign, 8'hFF, 23'd0} : {sign, e[7:0], m[22:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/grot_fmul.sv =====
// grot_fmul: three-stage binary32 multiplier, round to nearest even, canonical nan
// depends on grot_pkg

module grot_fmul import grot_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [FpW-1:0] a_i,
  input  logic [FpW-1:0] b_i,
  output logic [FpW-1:0] p_o
);

  fp_unp_t ua, ub;
  assign ua = fp_unpack(a_i);
  assign ub = fp_unpack(b_i);

  // stage 1: product of significands and special cases
  logic [47:0]        prod_q;
  logic signed [11:0] exp1_q;
  logic               sign1_q, nan1_q, inf1_q, zero1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 48'(ua.sig) * 48'(ub.sig);
      exp1_q  <= 12'($signed({2'b00, ua.exp}) + $signed({2'b00, ub.exp}) - 12'sd126);
      sign1_q <= ua.sign ^ ub.sign;
      nan1_q  <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_zero) | (ua.is_zero & ub.is_inf);
      inf1_q  <= ua.is_inf | ub.is_inf;
      zero1_q <= ua.is_zero | ub.is_zero;
    end
  end

  // stage 2: normalize
  logic [5:0]         lz;
  logic [47:0]        norm_q;
  logic signed [11:0] exp2_q;
  logic               sign2_q, nan2_q, inf2_q, zero2_q;
  assign lz = lzc48(prod_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q  <= prod_q << lz;
      exp2_q  <= exp1_q - 12'($unsigned(lz));
      sign2_q <= sign1_q;
      nan2_q  <= nan1_q;
      inf2_q  <= inf1_q;
      zero2_q <= zero1_q | (prod_q == '0);
    end
  end

  // stage 3: round
  logic [FpW-1:0] p_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (nan2_q)       p_q <= CanonNan;
      else if (inf2_q)  p_q <= {sign2_q, 8'hFF, 23'd0};
      else if (zero2_q) p_q <= {sign2_q, 31'd0};
      else              p_q <= fp_round(sign2_q, exp2_q, norm_q, 1'b0);
    end
  end
  assign p_o = p_q;

endmodule

// ===== rtl/grot_fadd.sv =====
// grot_fadd: three-stage binary32 adder, round to nearest even, canonical nan
// depends on grot_pkg

module grot_fadd import grot_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [FpW-1:0] a_i,
  input  logic [FpW-1:0] b_i,
  output logic [FpW-1:0] s_o
);

  fp_unp_t ua, ub, big, sml;
  logic    swap;
  logic [9:0] dexp;
  assign ua = fp_unpack(a_i);
  assign ub = fp_unpack(b_i);
  assign swap = (ub.exp > ua.exp) || ((ub.exp == ua.exp) && (ub.sig > ua.sig));
  assign big = swap ? ub : ua;
  assign sml = swap ? ua : ub;
  assign dexp = big.exp - sml.exp;

  // stage 1: align, 3 extra low bits plus sticky
  logic [27:0] bsig_q, ssig_q;
  logic [9:0]  exp1_q;
  logic        sign1_q, sub1_q, nan1_q, inf1_q, infs1_q, zz1_q, zzs1_q;
  logic [27:0] sh_full;
  logic        stk;

  always_comb begin
    sh_full = {sml.sig, 4'd0} >> ((dexp > 10'd27) ? 10'd27 : dexp);
    stk = 1'b0;
    for (int k = 0; k < 28; k++) begin
      if (k < int'(dexp)) stk = stk | (k >= 4 ? sml.sig[k-4] : 1'b0);
    end
    if (dexp > 10'd27) stk = (sml.sig != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsig_q  <= {big.sig, 4'd0};
      ssig_q  <= {sh_full[27:1], sh_full[0] | stk};
      exp1_q  <= big.exp;
      sign1_q <= big.sign;
      sub1_q  <= ua.sign ^ ub.sign;
      nan1_q  <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_inf & (ua.sign ^ ub.sign));
      inf1_q  <= ua.is_inf | ub.is_inf;
      infs1_q <= ua.is_inf ? ua.sign : ub.sign;
      zz1_q   <= ua.is_zero & ub.is_zero;
      zzs1_q  <= ua.sign & ub.sign;
    end
  end

  // stage 2: add or subtract, normalize
  logic [28:0] sum;
  logic [5:0]  lz;
  logic [47:0] norm_q;
  logic signed [11:0] exp2_q;
  logic        sign2_q, nan2_q, inf2_q, infs2_q, zero2_q, zs2_q;
  assign sum = sub1_q ? {1'b0, bsig_q} - {1'b0, ssig_q} : {1'b0, bsig_q} + {1'b0, ssig_q};
  assign lz  = lzc48({sum, 19'd0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q  <= {sum, 19'd0} << lz;
      exp2_q  <= 12'($signed({2'b00, exp1_q}) + 12'sd1 - 12'($unsigned(lz)));
      sign2_q <= sign1_q;
      nan2_q  <= nan1_q;
      inf2_q  <= inf1_q;
      infs2_q <= infs1_q;
      zero2_q <= (sum == '0);
      zs2_q   <= zz1_q ? zzs1_q : 1'b0;
    end
  end

  // stage 3: round
  logic [FpW-1:0] s_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (nan2_q)       s_q <= CanonNan;
      else if (inf2_q)  s_q <= {infs2_q, 8'hFF, 23'd0};
      else if (zero2_q) s_q <= {zs2_q, 31'd0};
      else              s_q <= fp_round(sign2_q, exp2_q, norm_q, 1'b0);
    end
  end
  assign s_o = s_q;

endmodule

// ===== rtl/givens_rotation_fp32_core.sv =====
// givens_rotation_fp32_core: top level of the binary32 plane rotation
// depends on grot_pkg, grot_fmul, grot_fadd
//
// Rotates pairs (x, y): x_out = c*x + s*y, y_out = c*y - s*x, each product and
// each sum rounded to nearest even, nan results as 0x7FC00000.
// Input channel: in_valid_i / in_stall_o with x_in_i, y_in_i, last_in_i.
// Output channel: out_valid_o / out_stall_i with x_out_o, y_out_o, last_out_o.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i 0 = cosine, 1 = sine;
// other indexes are ignored. Write only while the pipe is empty.
// When cosine is 1.0 and sine is +0 the pair passes through bit for bit.
// The pipe has three multiplier stages and three adder stages, and one item is
// accepted every cycle while no stage holds. The whole pipe advances as one unit: when the
// receiver stalls a full output stage, every stage holds, so in_stall_o
// follows out_stall_i whenever the last stage is occupied.
// Reset clears the valid bits and loads cosine 1.0 and sine +0.

module givens_rotation_fp32_core import grot_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FpW-1:0]     x_in_i,
  input  logic [FpW-1:0]     y_in_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FpW-1:0]     x_out_o,
  output logic [FpW-1:0]     y_out_o,
  output logic               last_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [FpW-1:0]     cfg_data_i
);

  localparam int unsigned Depth = 6;

  logic [FpW-1:0] cos_q, sin_q;
  logic           bypass;
  logic           en;

  assign cfg_ready_o = 1'b1;
  assign bypass = (cos_q == OneBits) && (sin_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= OneBits;
      sin_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COSINE: cos_q <= cfg_data_i;
        REG_SINE:   sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [Depth-1:0] vld_q;
  assign en = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // side data: inputs, last and bypass flag
  logic [FpW-1:0] xd_q [Depth];
  logic [FpW-1:0] yd_q [Depth];
  logic [Depth-1:0] ld_q, bp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q[0] <= x_in_i;
      yd_q[0] <= y_in_i;
      ld_q[0] <= last_in_i;
      bp_q[0] <= bypass;
      for (int i = 1; i < Depth; i++) begin
        xd_q[i] <= xd_q[i-1];
        yd_q[i] <= yd_q[i-1];
        ld_q[i] <= ld_q[i-1];
        bp_q[i] <= bp_q[i-1];
      end
    end
  end

  logic [FpW-1:0] cx, sy, cy, sx, xs, ys;

  grot_fmul u_mul_cx (.clk_i, .en_i(en), .a_i(cos_q), .b_i(x_in_i), .p_o(cx));
  grot_fmul u_mul_sy (.clk_i, .en_i(en), .a_i(sin_q), .b_i(y_in_i), .p_o(sy));
  grot_fmul u_mul_cy (.clk_i, .en_i(en), .a_i(cos_q), .b_i(y_in_i), .p_o(cy));
  grot_fmul u_mul_sx (.clk_i, .en_i(en), .a_i(sin_q), .b_i(x_in_i), .p_o(sx));

  grot_fadd u_add_x (.clk_i, .en_i(en), .a_i(cx), .b_i(sy), .s_o(xs));
  grot_fadd u_add_y (.clk_i, .en_i(en), .a_i(cy), .b_i({~sx[31], sx[30:0]}), .s_o(ys));

  assign out_valid_o = vld_q[Depth-1];
  assign x_out_o     = bp_q[Depth-1] ? xd_q[Depth-1] : xs;
  assign y_out_o     = bp_q[Depth-1] ? yd_q[Depth-1] : ys;
  assign last_out_o  = ld_q[Depth-1];

endmodule

// ===== verif/givens_rotation_fp32_core_test.sv =====
// givens_rotation_fp32_core_test: self-checking bench for the binary32 plane rotation core
// depends on grot_pkg and givens_rotation_fp32_core; predicts each pair with real arithmetic
// rounded to binary32 by hand, directed table first, then random phases with stalls

module givens_rotation_fp32_core_test;
  import grot_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandPhases = 9;
  localparam int unsigned PhaseItems = 145;

  typedef struct packed {
    logic [FpW-1:0] x;
    logic [FpW-1:0] y;
    logic           last;
  } pair_t;

  // one directed row: rotation setting, input pair, optional typed answer
  typedef struct packed {
    logic [FpW-1:0] cos_bits;
    logic [FpW-1:0] sin_bits;
    logic [FpW-1:0] x;
    logic [FpW-1:0] y;
    logic           last;
    logic           typed;
    logic [FpW-1:0] x_exp;
    logic [FpW-1:0] y_exp;
  } row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic [FpW-1:0] x_in;
  logic [FpW-1:0] y_in;
  logic           last_in;
  logic           out_valid;
  logic           out_stall;
  logic [FpW-1:0] x_out;
  logic [FpW-1:0] y_out;
  logic           last_out;
  logic           cfg_valid;
  logic           cfg_ready;
  cfg_reg_e       cfg_index;
  logic [FpW-1:0] cfg_data;

  logic [FpW-1:0] cos_reg;
  logic [FpW-1:0] sin_reg;
  pair_t          rotated_q[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  logic           hold_req;

  givens_rotation_fp32_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .x_in_i     (x_in),
    .y_in_i     (y_in),
    .last_in_i  (last_in),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .x_out_o    (x_out),
    .y_out_o    (y_out),
    .last_out_o (last_out),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // binary32 pattern to an exact double
  function automatic real fp_to_real(input logic [FpW-1:0] b);
    logic [7:0]  e;
    logic [22:0] m;
    real         r;
    e = b[30:23];
    m = b[22:0];
    if (e == 8'hFF) return $bitstoreal({b[31], 11'h7FF, m, 29'b0});
    if (e == 8'd0) begin
      if (m == '0) return $bitstoreal({b[31], 63'b0});
      // scale by 2^-149
      r = $itor(m) * $bitstoreal(64'h36A0_0000_0000_0000);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(e) + 11'd896, m, 29'b0});
  endfunction

  // double to binary32, nearest even, with subnormals and overflow to infinity
  function automatic logic [FpW-1:0] real_to_fp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] val;
    int          ue;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != '0) return CanonNan;
      return {d[63], 8'hFF, 23'b0};
    end
    if (d[62:52] == 11'd0) return {d[63], 31'b0};
    ue  = int'(d[62:52]) - 1023;
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = (ue >= -126) ? 29 : 29 + (-126 - ue);
    if (sh > 60) return {d[63], 31'b0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (ue < -126) return {d[63], kept[30:0]};
    val = (64'(ue + 126) << 23) + kept;
    if (val >= 64'h7F80_0000) return {d[63], 8'hFF, 23'b0};
    return {d[63], val[30:0]};
  endfunction

  function automatic logic [FpW-1:0] fp_mul(input logic [FpW-1:0] a, input logic [FpW-1:0] b);
    return real_to_fp(fp_to_real(a) * fp_to_real(b));
  endfunction

  function automatic logic [FpW-1:0] fp_add(input logic [FpW-1:0] a, input logic [FpW-1:0] b);
    return real_to_fp(fp_to_real(a) + fp_to_real(b));
  endfunction

  function automatic logic [FpW-1:0] quiet(input logic [FpW-1:0] b);
    if (b[30:23] == 8'hFF && b[22:0] != '0) return CanonNan;
    return b;
  endfunction

  function automatic pair_t rotate_pair(input logic [FpW-1:0] x, input logic [FpW-1:0] y,
                                        input logic last);
    pair_t p;
    p.last = last;
    if (cos_reg == OneBits && sin_reg == '0) begin
      p.x = x;
      p.y = y;
    end else begin
      p.x = quiet(fp_add(fp_mul(cos_reg, x), fp_mul(sin_reg, y)));
      p.y = quiet(fp_add(fp_mul(cos_reg, y), fp_mul(sin_reg, x) ^ 32'h8000_0000));
    end
    return p;
  endfunction

  // random binary32 operand: raw bits, moderate magnitudes or special patterns
  function automatic logic [FpW-1:0] rand_fp();
    logic [FpW-1:0] b;
    int unsigned    pick;
    pick = $urandom_range(0, 9);
    b = $urandom();
    if (pick < 3) return b;
    if (pick < 8) return {b[31], 8'($urandom_range(100, 154)), b[22:0]};
    case ($urandom_range(0, 6))
      0: return {b[31], 31'b0};
      1: return {b[31], 8'hFF, 23'b0};
      2: return {b[31], 8'hFF, b[22:0] | 23'd1};
      3: return {b[31], 8'h00, b[22:0]};
      4: return {b[31], 8'hFE, 23'h7FFFFF};
      5: return {b[31], 8'($urandom_range(1, 24)), b[22:0]};
      default: return {b[31], 8'($urandom_range(230, 254)), b[22:0]};
    endcase
  endfunction

  // valid stays high; the caller drops it after its last write
  task automatic write_reg(input cfg_reg_e idx, input logic [FpW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COSINE) cos_reg = data;
    else sin_reg = data;
  endtask

  // wait for the pipe to empty, then load a new rotation
  task automatic set_rotation(input logic [FpW-1:0] c, input logic [FpW-1:0] s);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    write_reg(REG_COSINE, c);
    write_reg(REG_SINE, s);
    cfg_valid <= 1'b0;
  endtask

  // offer one item until taken; the expectation is queued at the accepting edge
  task automatic send_pair(input logic [FpW-1:0] x, input logic [FpW-1:0] y, input logic last,
                           input logic typed, input pair_t answer);
    in_valid <= 1'b1;
    x_in     <= x;
    y_in     <= y;
    last_in  <= last;
    do @(posedge clk); while (in_stall);
    rotated_q.push_back(typed ? answer : rotate_pair(x, y, last));
  endtask

  // sender works in bursts with random gaps
  int unsigned burst_left;
  task automatic maybe_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  row_t dir_rows[$];

  initial begin
    pair_t answer;
    row_t  row;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    x_in      = '0;
    y_in      = '0;
    last_in   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_COSINE;
    cfg_data  = '0;
    hold_req  = 1'b0;
    burst_left = 0;
    cos_reg   = OneBits;
    sin_reg   = '0;

    // reset values give bit-exact pass-through
    dir_rows.push_back({OneBits, 32'h0, 32'h7FA1_2345, 32'hFFFF_FFFF, 1'b1,
                        1'b1, 32'h7FA1_2345, 32'hFFFF_FFFF});
    dir_rows.push_back({OneBits, 32'h0, 32'h0000_0000, 32'h8000_0000, 1'b0,
                        1'b1, 32'h0000_0000, 32'h8000_0000});
    dir_rows.push_back({OneBits, 32'h0, 32'h0000_0001, 32'h7F7F_FFFF, 1'b1,
                        1'b1, 32'h0000_0001, 32'h7F7F_FFFF});
    // negative zero sine leaves bypass, nan goes canonical
    dir_rows.push_back({OneBits, 32'h8000_0000, 32'h7F80_0001, OneBits, 1'b0,
                        1'b1, CanonNan, CanonNan});
    dir_rows.push_back({OneBits, 32'h8000_0000, 32'h4040_0000, 32'hC000_0000, 1'b1,
                        1'b0, 32'h0, 32'h0});
    // quarter turn swaps the pair and negates the new y
    dir_rows.push_back({32'h0, OneBits, OneBits, 32'h4000_0000, 1'b0,
                        1'b1, 32'h4000_0000, 32'hBF80_0000});
    dir_rows.push_back({32'h0, 32'h0, 32'hFF80_0000, 32'h3F80_0000, 1'b1,
                        1'b0, 32'h0, 32'h0});
    dir_rows.push_back({32'h0, 32'h0, 32'h4000_0000, 32'hC000_0000, 1'b0,
                        1'b0, 32'h0, 32'h0});
    // overflow to infinity
    dir_rows.push_back({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1,
                        1'b0, 32'h0, 32'h0});
    dir_rows.push_back({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 1'b0,
                        1'b0, 32'h0, 32'h0});
    // subnormal products and sums
    dir_rows.push_back({32'h0000_0001, 32'h0080_0000, 32'h0000_0001, 32'h3F00_0000, 1'b1,
                        1'b0, 32'h0, 32'h0});
    dir_rows.push_back({32'h0000_0001, 32'h0080_0000, 32'h4B00_0000, 32'h807F_FFFF, 1'b0,
                        1'b0, 32'h0, 32'h0});
    // infinity times zero and infinity minus infinity
    dir_rows.push_back({32'h7F80_0000, 32'h0, 32'h0, OneBits, 1'b1,
                        1'b1, CanonNan, 32'h7F80_0000});
    dir_rows.push_back({32'h7F80_0000, 32'h7F80_0000, OneBits, OneBits, 1'b0,
                        1'b1, 32'h7F80_0000, CanonNan});
    // all-ones registers are nan
    dir_rows.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1,
                        1'b1, CanonNan, CanonNan});
    // a real angle, 0.6 / 0.8
    dir_rows.push_back({32'h3F19_999A, 32'h3F4C_CCCD, 32'h4040_0000, 32'h4080_0000, 1'b0,
                        1'b0, 32'h0, 32'h0});
    dir_rows.push_back({32'h3F19_999A, 32'h3F4C_CCCD, 32'h8000_0001, 32'h7FFF_FFFF, 1'b1,
                        1'b0, 32'h0, 32'h0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cos_bits != cos_reg || row.sin_bits != sin_reg)
        set_rotation(row.cos_bits, row.sin_bits);
      answer = '{x: row.x_exp, y: row.y_exp, last: row.last};
      send_pair(row.x, row.y, row.last, row.typed, answer);
      maybe_gap();
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph % 4)
        0: set_rotation(32'(rand_fp()) & 32'h3FFF_FFFF | 32'h3E00_0000, rand_fp());
        1: set_rotation(OneBits, 32'h0);
        2: set_rotation($urandom(), $urandom());
        default: set_rotation(rand_fp(), rand_fp());
      endcase
      // long hold-off starts once the sender is streaming
      if (ph == 0) hold_req <= 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        send_pair(rand_fp(), rand_fp(), 1'($urandom_range(0, 1)), 1'b0, '0);
        maybe_gap();
      end
    end
    in_valid <= 1'b0;

    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off while the sender keeps offering
  initial begin
    int unsigned mode;
    int unsigned span;
    logic        held;
    out_stall = 1'b0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(5, 60);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      for (int i = 0; i < span; i++) begin
        if (mode < 3) out_stall <= 1'b0;
        else if (mode < 8) out_stall <= ($urandom_range(0, 2) == 0);
        else out_stall <= (i % 3 != 0);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected item x_out=%h y_out=%h", x_out, y_out);
        errors++;
      end else begin
        want = rotated_q.pop_front();
        if (x_out !== want.x) begin
          $error("x_out expected %h actual %h", want.x, x_out);
          errors++;
        end
        if (y_out !== want.y) begin
          $error("y_out expected %h actual %h", want.y, y_out);
          errors++;
        end
        if (last_out !== want.last) begin
          $error("last_out expected %b actual %b", want.last, last_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/grot_pkg.sv
rtl/grot_fmul.sv
rtl/grot_fadd.sv
rtl/givens_rotation_fp32_core.sv
verif/givens_rotation_fp32_core_test.sv
